[rtl/core/ipwd_pkg.sv]
// ----------------------------------------------------------------------------
// ipwd_pkg
// shared types and constants for the pulse width decoder
// ----------------------------------------------------------------------------
package ipwd_pkg;

  localparam int unsigned WidthW  = 16;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned IdleW   = 4;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned RepeatW = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 3;

  // idle tick limits, counter limits and repeat threshold
  localparam logic [IdleW-1:0]   IdleDropNoRepeat = IdleW'(3);
  localparam logic [IdleW-1:0]   IdleDropMax      = IdleW'(9);
  localparam logic [IdleW-1:0]   IdleTicksMax     = '1;
  localparam logic [BitsW-1:0]   BitsSeenMax      = '1;
  localparam logic [RepeatW-1:0] RepeatsMax       = '1;
  localparam logic [RepeatW-1:0] RepeatBitThresh  = RepeatW'(3);

  // window reset values, microseconds
  localparam logic [WidthW-1:0] ZeroMinRst   = WidthW'(300);
  localparam logic [WidthW-1:0] ZeroMaxRst   = WidthW'(800);
  localparam logic [WidthW-1:0] OneMinRst    = WidthW'(1400);
  localparam logic [WidthW-1:0] OneMaxRst    = WidthW'(1800);
  localparam logic [WidthW-1:0] RepeatMinRst = WidthW'(2100);
  localparam logic [WidthW-1:0] RepeatMaxRst = WidthW'(2500);
  localparam logic [WidthW-1:0] LeaderMinRst = WidthW'(4200);
  localparam logic [WidthW-1:0] LeaderMaxRst = WidthW'(4700);

  typedef enum logic [OpW-1:0] {
    OP_TICK = 2'd0,
    OP_RISE = 2'd1,
    OP_FALL = 2'd2
  } ipwd_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_MIN   = 3'd0,
    REG_ZERO_MAX   = 3'd1,
    REG_ONE_MIN    = 3'd2,
    REG_ONE_MAX    = 3'd3,
    REG_REPEAT_MIN = 3'd4,
    REG_REPEAT_MAX = 3'd5,
    REG_LEADER_MIN = 3'd6,
    REG_LEADER_MAX = 3'd7
  } ipwd_reg_e;

  typedef struct packed {
    logic [WidthW-1:0] zero_min;
    logic [WidthW-1:0] zero_max;
    logic [WidthW-1:0] one_min;
    logic [WidthW-1:0] one_max;
    logic [WidthW-1:0] repeat_min;
    logic [WidthW-1:0] repeat_max;
    logic [WidthW-1:0] leader_min;
    logic [WidthW-1:0] leader_max;
  } ipwd_cfg_t;

  typedef struct packed {
    logic zero;
    logic one;
    logic rpt;
    logic leader;
  } ipwd_hit_t;

endpackage

[rtl/core/ipwd_window.sv]
// ----------------------------------------------------------------------------
// ipwd_window
// classifies a pulse width against the four windows, bounds exclusive
// ----------------------------------------------------------------------------
module ipwd_window import ipwd_pkg::*; (
  input  logic [WidthW-1:0] width_i,
  input  ipwd_cfg_t         cfg_i,
  output ipwd_hit_t         hit_o
);

  function automatic logic in_win(logic [WidthW-1:0] w, logic [WidthW-1:0] lo,
                                  logic [WidthW-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

  assign hit_o.zero   = in_win(width_i, cfg_i.zero_min, cfg_i.zero_max);
  assign hit_o.one    = in_win(width_i, cfg_i.one_min, cfg_i.one_max);
  assign hit_o.rpt    = in_win(width_i, cfg_i.repeat_min, cfg_i.repeat_max);
  assign hit_o.leader = in_win(width_i, cfg_i.leader_min, cfg_i.leader_max);

endmodule

[rtl/core/ir_pulse_width_decoder_top.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_top
// NEC style infrared frame decoder driven by edge and tick events
// ----------------------------------------------------------------------------
// Every request is one event: a timeout tick, a rising edge, or a falling
// edge with its measured pulse width in microseconds. The block takes one
// request per clock cycle while the input is not stalled; each request
// produces exactly one result: the window compare and state update run on
// the input register and load the result register once it is free. The
// result register sits between the two sides, so a new request is taken
// while an earlier result still waits, and the input only stalls once both
// registers are full and the output is stalled. A key code is flagged when
// the bit count steps onto CAPTURE_BITS. The eight window bounds are written
// through the configuration port; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ir_pulse_width_decoder_top import ipwd_pkg::*; #(
  parameter int unsigned CAPTURE_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [WidthW-1:0]  pulse_width_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               key_valid_o,
  output logic [KeyW-1:0]    key_code_o,
  output logic               frame_active_o,
  output logic [RepeatW-1:0] repeat_total_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WidthW-1:0]  cfg_data_i
);

  // bit count at which the key code is captured
  localparam logic [BitsW-1:0] CaptureCnt = BitsW'(CAPTURE_BITS);

  // configuration registers
  ipwd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{zero_min:   ZeroMinRst,   zero_max:   ZeroMaxRst,
                 one_min:    OneMinRst,    one_max:    OneMaxRst,
                 repeat_min: RepeatMinRst, repeat_max: RepeatMaxRst,
                 leader_min: LeaderMinRst, leader_max: LeaderMaxRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ZERO_MIN:   cfg_q.zero_min   <= cfg_data_i;
        REG_ZERO_MAX:   cfg_q.zero_max   <= cfg_data_i;
        REG_ONE_MIN:    cfg_q.one_min    <= cfg_data_i;
        REG_ONE_MAX:    cfg_q.one_max    <= cfg_data_i;
        REG_REPEAT_MIN: cfg_q.repeat_min <= cfg_data_i;
        REG_REPEAT_MAX: cfg_q.repeat_max <= cfg_data_i;
        REG_LEADER_MIN: cfg_q.leader_min <= cfg_data_i;
        REG_LEADER_MAX: cfg_q.leader_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: result register frees up when empty or being taken
  logic out_ready;
  logic s1_valid_q;
  logic s1_adv;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign s1_adv     = s1_valid_q && out_ready;

  // input register
  logic [OpW-1:0]    op_q;
  logic [WidthW-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= operation_i;
      width_q <= pulse_width_i;
    end
  end

  // window classification of the registered width
  ipwd_hit_t hit;

  ipwd_window u_window (
    .width_i (width_q),
    .cfg_i   (cfg_q),
    .hit_o   (hit)
  );

  // decoder state
  logic               active_q,  active_d;
  logic               phase_q,   phase_d;
  logic [IdleW-1:0]   idle_q,    idle_d;
  logic [KeyW-1:0]    shift_q,   shift_d;
  logic [BitsW-1:0]   bits_q,    bits_d;
  logic [RepeatW-1:0] repeats_q, repeats_d;
  logic [KeyW-1:0]    held_q,    held_d;
  logic               capture;
  logic               count_bit;

  always_comb begin
    active_d  = active_q;
    phase_d   = phase_q;
    idle_d    = idle_q;
    shift_d   = shift_q;
    repeats_d = repeats_q;
    held_d    = held_q;
    count_bit = 1'b0;
    capture   = 1'b0;

    unique case (op_q)
      OP_TICK: begin
        if (active_q) begin
          // drop the frame after enough idle ticks
          if ((idle_q > IdleDropNoRepeat) &&
              ((repeats_q == '0) || (idle_q > IdleDropMax))) begin
            active_d = 1'b0;
          end
          if (idle_q != IdleTicksMax) begin
            idle_d = idle_q + IdleW'(1);
          end
        end
      end
      OP_RISE: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          idle_d  = '0;
        end
      end
      OP_FALL: begin
        if (phase_q) begin
          phase_d = 1'b0;
          if (active_q) begin
            priority if (hit.zero) begin
              shift_d   = {shift_q[KeyW-2:0], 1'b0};
              count_bit = 1'b1;
            end else if (hit.one) begin
              shift_d   = {shift_q[KeyW-2:0], 1'b1};
              count_bit = 1'b1;
            end else if (hit.rpt) begin
              count_bit = (repeats_q > RepeatBitThresh);
              if (repeats_q != RepeatsMax) begin
                repeats_d = repeats_q + RepeatW'(1);
              end
            end else begin
              // width outside every window
            end
          end else if (hit.leader) begin
            active_d  = 1'b1;
            repeats_d = '0;
          end
        end
      end
      default: ;
    endcase

    // bit counter, saturating; a leader restarts it
    if (count_bit && (bits_q != BitsSeenMax)) begin
      bits_d  = bits_q + BitsW'(1);
      capture = ((bits_q + BitsW'(1)) == CaptureCnt);
    end else if (active_d && !active_q) begin
      bits_d  = '0;
    end else begin
      bits_d  = bits_q;
    end

    // key capture on the step onto the capture count
    if (capture) begin
      held_d  = shift_d;
      shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      phase_q   <= 1'b0;
      idle_q    <= '0;
      shift_q   <= '0;
      bits_q    <= '0;
      repeats_q <= '0;
      held_q    <= '0;
    end else if (s1_adv) begin
      active_q  <= active_d;
      phase_q   <= phase_d;
      idle_q    <= idle_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      repeats_q <= repeats_d;
      held_q    <= held_d;
    end
  end

  // result register
  logic               out_valid_q;
  logic               key_valid_q;
  logic [KeyW-1:0]    key_code_q;
  logic               frame_active_q;
  logic [RepeatW-1:0] repeat_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      key_valid_q    <= capture;
      key_code_q     <= held_d;
      frame_active_q <= active_d;
      repeat_total_q <= repeats_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_valid_o    = key_valid_q;
  assign key_code_o     = key_code_q;
  assign frame_active_o = frame_active_q;
  assign repeat_total_o = repeat_total_q;

  // a flagged key matches the bit count and cleared shifter it left behind
  a_key_at_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && key_valid_q |-> (bits_q == CaptureCnt) && (shift_q == '0))
    else $error("key flagged without capture count");

  // the result register mirrors the state it was loaded with
  a_result_mirrors_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (frame_active_q == active_q) && (repeat_total_q == repeats_q)
                    && (key_code_q == held_q))
    else $error("result out of step with decoder state");

  // a new frame starts with cleared counters
  a_frame_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> (bits_q == '0) && (repeats_q == '0))
    else $error("frame started with stale counters");

  // a request held in the input register is not lost while blocked
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ready |=> s1_valid_q && $stable(op_q) && $stable(width_q))
    else $error("blocked request lost");

endmodule
